// ===== src/assert_macros.svh =====
// Assertion macros shared by the MinHash signature RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define MHS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: assertion failed");

// Checked at every rising edge, reset included.
`define MHS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

// ===== src/mhs_pkg.sv =====
// Package for the MinHash signature block: field widths, op codes and types.
// No dependencies; used by every module of the block.
`default_nettype none

package mhs_pkg;

    localparam int MHS_NUM_HASHES = 8;
    localparam int MHS_ROWS       = 1024;

    localparam int OP_W   = 2;
    localparam int HASH_W = 3;
    localparam int ROW_W  = 10;
    localparam int VAL_W  = 10;
    localparam int CNT_W  = 4;
    localparam int SLOTS  = 8;

    localparam logic [CNT_W-1:0] ACTIVE_RESET = 4'd8;

    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
    localparam logic [OP_W-1:0] OP_ADD   = 2'd2;
    localparam logic [OP_W-1:0] OP_READ  = 2'd3;

    typedef logic [VAL_W-1:0] t_val;

    // Command from the issue stage to the signature slot bank.
    typedef struct packed {
        logic               clear;
        logic               add;
        logic [CNT_W-1:0]   count;
        logic [HASH_W-1:0]  rd_hash;
    } t_slot_cmd;

endpackage

`default_nettype wire

// ===== src/minhash_signature_update.sv =====
// MinHash signature update block, top level.
// Depends on mhs_pkg, mhs_perm_lane, mhs_slot_bank and assert_macros.svh.
//
// Usage: items enter on the input channel (i_in_valid/o_in_ready) with fields
// op, hash_index, row_index and perm_value. Clear, load and add produce no
// output beat; a read produces one beat (min_value, is_empty) on the output
// channel (o_out_valid/i_out_ready). The active hash count is written through
// the configuration channel (i_cfg_valid/o_cfg_ready/i_cfg_data), which is
// always ready and should only be used while the block is idle.
// Throughput: one item per cycle while o_in_ready is high. An item is
// registered on acceptance while its permutation entries are read from the
// lane memories; the next edge updates the slots. A read result passes the
// issue-stage register and then, once it is free, the output register.
// When the receiver stalls, one result waits in the output register and the
// block keeps accepting items until a second read reaches the issue stage;
// then o_in_ready drops until the output beat is taken.
// Reset empties all slots and sets the active count to eight; the permutation
// table is not cleared and must be loaded before adds use it.
`default_nettype none
`include "assert_macros.svh"

module minhash_signature_update
    import mhs_pkg::*;
#(
    parameter int NUM_HASHES = MHS_NUM_HASHES,
    parameter int ROWS       = MHS_ROWS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [OP_W-1:0]    i_op,
    input  wire logic [HASH_W-1:0]  i_hash_index,
    input  wire logic [ROW_W-1:0]   i_row_index,
    input  wire logic [VAL_W-1:0]   i_perm_value,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [VAL_W-1:0]        o_min_value,
    output logic                    o_is_empty,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [CNT_W-1:0]   i_cfg_data
);

    localparam int NumLanes  = (NUM_HASHES < SLOTS) ? NUM_HASHES : SLOTS;
    localparam int LaneDepth = (ROWS < 2**ROW_W) ? ROWS : 2**ROW_W;
    localparam int LaneAw    = $clog2(LaneDepth);
    localparam logic RowsCover = (ROWS >= 2**ROW_W);

    logic [CNT_W-1:0]   r_active;
    logic               r_s1_valid;
    logic [OP_W-1:0]    r_s1_op;
    logic [HASH_W-1:0]  r_s1_hash;
    logic               r_s1_row_ok;
    logic               r_out_valid;
    t_val               r_min_value;
    logic               r_is_empty;

    logic               in_accept;
    logic               row_ok;
    logic               s1_stall;
    logic               s1_read_go;
    logic [CNT_W-1:0]   eff_count;
    t_val               lane_data [SLOTS];
    t_slot_cmd          slot_cmd;
    t_val               rd_value;
    logic               rd_empty;

    assign row_ok    = RowsCover || (32'(i_row_index) < ROWS);
    assign in_accept = i_in_valid && o_in_ready;

    // A read in the issue stage waits while the output register is full and not being taken.
    assign s1_stall   = r_s1_valid && (r_s1_op == OP_READ) && r_out_valid && !i_out_ready;
    assign s1_read_go = r_s1_valid && (r_s1_op == OP_READ) && !s1_stall;
    assign o_in_ready = !s1_stall;
    assign o_cfg_ready = 1'b1;

    assign eff_count = (r_active > CNT_W'(NumLanes)) ? CNT_W'(NumLanes) : r_active;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= ACTIVE_RESET;
        end else if (i_cfg_valid) begin
            r_active <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_op     <= i_op;
            r_s1_hash   <= i_hash_index;
            r_s1_row_ok <= row_ok;
        end
    end

    genvar g;
    generate
        for (g = 0; g < SLOTS; g++) begin : g_lane
            if (g < NumLanes) begin : g_mem
                logic lane_we;
                assign lane_we = in_accept && (i_op == OP_LOAD) && row_ok &&
                                 (i_hash_index == HASH_W'(g));
                mhs_perm_lane #(
                    .DEPTH (LaneDepth)
                ) u_lane (
                    .i_clk     (i_clk),
                    .i_we      (lane_we),
                    .i_re      (in_accept),
                    .i_addr    (i_row_index[LaneAw-1:0]),
                    .i_wr_data (i_perm_value),
                    .o_rd_data (lane_data[g])
                );
            end else begin : g_none
                assign lane_data[g] = '0;
            end
        end
    endgenerate

    always_comb begin
        slot_cmd.clear   = r_s1_valid && (r_s1_op == OP_CLEAR);
        slot_cmd.add     = r_s1_valid && (r_s1_op == OP_ADD) && r_s1_row_ok;
        slot_cmd.count   = eff_count;
        slot_cmd.rd_hash = r_s1_hash;
    end

    mhs_slot_bank u_slots (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (slot_cmd),
        .i_lane_data (lane_data),
        .o_rd_value  (rd_value),
        .o_rd_empty  (rd_empty)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_read_go) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_read_go) begin
            r_min_value <= rd_value;
            r_is_empty  <= rd_empty;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_min_value = r_min_value;
    assign o_is_empty  = r_is_empty;

    `MHS_ASSERT(a_beat_from_read, i_clk, i_rst_n,
        $rose(o_out_valid) |-> $past(r_s1_valid && (r_s1_op == OP_READ)))
    `MHS_ASSERT(a_ready_only_stall, i_clk, i_rst_n,
        !o_in_ready |-> (r_s1_valid && (r_s1_op == OP_READ) && o_out_valid && !i_out_ready))
    `MHS_ASSERT(a_empty_zero, i_clk, i_rst_n,
        (o_out_valid && o_is_empty) |-> (o_min_value == '0))
    `MHS_ASSERT(a_count_capped, i_clk, i_rst_n,
        eff_count <= CNT_W'(NumLanes))

endmodule

`default_nettype wire

// ===== src/mhs_perm_lane.sv =====
// One permutation table lane: a single-port memory with registered read.
// Depends on mhs_pkg.
`default_nettype none

module mhs_perm_lane
    import mhs_pkg::*;
#(
    parameter int DEPTH = MHS_ROWS
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic                       i_re,
    input  wire logic [$clog2(DEPTH)-1:0]   i_addr,
    input  wire t_val                       i_wr_data,
    output t_val                            o_rd_data
);

    t_val r_mem [DEPTH];
    t_val r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wr_data;
        end
        if (i_re) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== src/mhs_slot_bank.sv =====
// Signature slots with their empty flags: min update, clear and read select.
// Depends on mhs_pkg.
`default_nettype none

module mhs_slot_bank
    import mhs_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_slot_cmd  i_cmd,
    input  wire t_val       i_lane_data [SLOTS],
    output t_val            o_rd_value,
    output logic            o_rd_empty
);

    t_val r_slot  [SLOTS];
    logic [SLOTS-1:0] r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            for (int i = 0; i < SLOTS; i++) begin
                r_slot[i] <= '0;
            end
        end else if (i_cmd.clear) begin
            r_valid <= '0;
            for (int i = 0; i < SLOTS; i++) begin
                r_slot[i] <= '0;
            end
        end else if (i_cmd.add) begin
            for (int i = 0; i < SLOTS; i++) begin
                if (CNT_W'(i) < i_cmd.count &&
                    (!r_valid[i] || r_slot[i] > i_lane_data[i])) begin
                    r_slot[i]  <= i_lane_data[i];
                    r_valid[i] <= 1'b1;
                end
            end
        end
    end

    // Slots at or beyond the active count read as empty with a zero value.
    always_comb begin
        o_rd_empty = !(({1'b0, i_cmd.rd_hash} < i_cmd.count) && r_valid[i_cmd.rd_hash]);
        o_rd_value = o_rd_empty ? '0 : r_slot[i_cmd.rd_hash];
    end

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for minhash_signature_update: a behavioral signature
// model predicts every read beat, and a scoreboard compares the DUT against it.
// Depends on mhs_pkg and the minhash_signature_update RTL.
`default_nettype none

module testbench;
    import mhs_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 4;
    localparam int LONG_HOLD     = 250;
    localparam int PHASE_ITEMS   = 80;

    typedef struct packed {
        t_val min_value;
        logic is_empty;
    } slot_read_t;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [OP_W-1:0]    i_op;
    logic [HASH_W-1:0]  i_hash_index;
    logic [ROW_W-1:0]   i_row_index;
    logic [VAL_W-1:0]   i_perm_value;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [VAL_W-1:0]   o_min_value;
    logic               o_is_empty;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [CNT_W-1:0]   i_cfg_data;

    // Signature model state.
    bit [VAL_W-1:0]     slot_min [SLOTS];
    bit                 slot_filled [SLOTS];
    bit [VAL_W-1:0]     perm_mem [MHS_NUM_HASHES][MHS_ROWS];
    bit                 perm_loaded [MHS_NUM_HASHES][MHS_ROWS];
    logic [CNT_W-1:0]   active_cfg = ACTIVE_RESET;
    int unsigned        full_rows [$];
    slot_read_t         pending_reads [$];
    slot_read_t         read_due;

    int unsigned        mismatches = 0;
    int unsigned        items_sent = 0;
    int unsigned        adds_sent = 0;
    int unsigned        loads_sent = 0;
    int unsigned        clears_sent = 0;
    int unsigned        reads_empty = 0;
    int unsigned        reads_filled = 0;
    int unsigned        cfg_writes = 0;
    int unsigned        stall_cycles = 0;
    int unsigned        out_hold_cycles = 0;
    int unsigned        rx_mode = 0;
    int unsigned        rx_left = 0;
    int                 burst_left = 0;

    minhash_signature_update DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_op         (i_op),
        .i_hash_index (i_hash_index),
        .i_row_index  (i_row_index),
        .i_perm_value (i_perm_value),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_min_value  (o_min_value),
        .o_is_empty   (o_is_empty),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int unsigned live_slots();
        return (active_cfg > MHS_NUM_HASHES) ? MHS_NUM_HASHES : active_cfg;
    endfunction

    // Applies one accepted item to the model and queues the read beat it causes.
    function automatic void apply_to_signature(logic [OP_W-1:0] op, logic [HASH_W-1:0] hash,
                                               logic [ROW_W-1:0] row, t_val pv);
        int unsigned n;
        bit [VAL_W-1:0] p;
        n = live_slots();
        case (op)
            OP_CLEAR: begin
                for (int i = 0; i < SLOTS; i++) begin
                    slot_min[i] = '0;
                    slot_filled[i] = 1'b0;
                end
            end
            OP_LOAD: begin
                if (hash < MHS_NUM_HASHES && row < MHS_ROWS) begin
                    perm_mem[hash][row] = pv;
                    perm_loaded[hash][row] = 1'b1;
                end
            end
            OP_ADD: begin
                if (row < MHS_ROWS) begin
                    for (int i = 0; i < n; i++) begin
                        p = perm_mem[i][row];
                        if (!slot_filled[i] || slot_min[i] > p) begin
                            slot_min[i] = p;
                            slot_filled[i] = 1'b1;
                        end
                    end
                end
            end
            default: begin
                if (hash < n && slot_filled[hash])
                    pending_reads.push_back('{min_value: slot_min[hash], is_empty: 1'b0});
                else
                    pending_reads.push_back('{min_value: '0, is_empty: 1'b1});
            end
        endcase
    endfunction

    // A row that an add may use: every active permutation has its entry loaded.
    function automatic logic [ROW_W-1:0] pick_add_row();
        int unsigned n;
        int unsigned r;
        bit ok;
        n = live_slots();
        r = $urandom_range(0, MHS_ROWS - 1);
        ok = 1'b1;
        for (int i = 0; i < n; i++)
            if (!perm_loaded[i][r])
                ok = 1'b0;
        if (!ok)
            r = full_rows[$urandom_range(0, full_rows.size() - 1)];
        return ROW_W'(r);
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    // with valid still high, so back-to-back beats follow without a gap.
    task automatic send_item(logic [OP_W-1:0] op, logic [HASH_W-1:0] hash,
                             logic [ROW_W-1:0] row, t_val pv);
        i_in_valid   <= 1'b1;
        i_op         <= op;
        i_hash_index <= hash;
        i_row_index  <= row;
        i_perm_value <= pv;
        do @(posedge i_clk); while (!o_in_ready);
        apply_to_signature(op, hash, row, pv);
        items_sent++;
        case (op)
            OP_CLEAR: clears_sent++;
            OP_LOAD:  loads_sent++;
            OP_ADD:   adds_sent++;
            default:  ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic pause_sender(int unsigned cycles);
        i_in_valid <= 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    task automatic send_paced(logic [OP_W-1:0] op, logic [HASH_W-1:0] hash,
                              logic [ROW_W-1:0] row, t_val pv);
        send_item(op, hash, row, pv);
        burst_left--;
        if (burst_left <= 0) begin
            pause_sender($urandom_range(1, 12));
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 16);
        end
    endtask

    task automatic wait_for_reads();
        i_in_valid <= 1'b0;
        while (pending_reads.size() != 0)
            @(negedge i_clk);
    endtask

    // Adds still in the pipeline leave no result behind, so let them settle too.
    task automatic set_active_hashes(logic [CNT_W-1:0] count);
        wait_for_reads();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= count;
        do @(posedge i_clk); while (!o_cfg_ready);
        active_cfg = count;
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_state();
        send_item(OP_READ, '0, '0, '0);
        send_item(OP_READ, '1, '1, '1);
        pause_sender(3);
    endtask

    // Empty slots take the permuted index of the first add directly.
    task automatic test_first_add();
        t_val first_perm [MHS_NUM_HASHES] = '{10'd1023, 10'd0, 10'd512, 10'd341,
                                              10'd682, 10'd1, 10'd1022, 10'd5};
        for (int h = 0; h < MHS_NUM_HASHES; h++)
            send_item(OP_LOAD, HASH_W'(h), '1, first_perm[h]);
        full_rows.push_back(MHS_ROWS - 1);
        send_item(OP_ADD, '1, '1, '1);
        send_item(OP_READ, 3'd0, '0, '0);
        send_item(OP_READ, 3'd1, '0, '0);
        send_item(OP_READ, 3'd7, '0, '0);
        pause_sender(2);
    endtask

    // Slots beyond the active count keep their contents but read as empty;
    // counts above eight saturate and zero disables every slot.
    task automatic test_active_count();
        set_active_hashes(4'd1);
        send_item(OP_LOAD, 3'd0, '0, 10'd7);
        send_item(OP_ADD, 3'd0, '0, '0);
        send_item(OP_READ, 3'd0, '0, '0);
        send_item(OP_READ, 3'd5, '0, '0);
        set_active_hashes(4'd15);
        send_item(OP_READ, 3'd5, '0, '0);
        set_active_hashes(4'd0);
        send_item(OP_ADD, 3'd0, '0, '0);
        send_item(OP_READ, 3'd0, '0, '0);
    endtask

    task automatic test_clear();
        set_active_hashes(4'd8);
        send_item(OP_CLEAR, '1, '1, '1);
        send_item(OP_READ, 3'd1, '0, '0);
        pause_sender(2);
    endtask

    // The receiver holds off long enough for the block to fill and drop o_in_ready.
    task automatic test_output_stall();
        out_hold_cycles = LONG_HOLD;
        for (int i = 0; i < 6; i++)
            send_item(OP_ADD, HASH_W'($urandom), pick_add_row(), VAL_W'($urandom));
        for (int i = 0; i < 30; i++)
            send_item(OP_READ, HASH_W'($urandom), ROW_W'($urandom), VAL_W'($urandom));
        wait_for_reads();
    endtask

    task automatic fill_row(logic [ROW_W-1:0] row);
        for (int h = 0; h < MHS_NUM_HASHES; h++)
            send_paced(OP_LOAD, HASH_W'(h), row, VAL_W'($urandom_range(0, MHS_ROWS - 1)));
        full_rows.push_back(row);
    endtask

    task automatic random_item();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 2)
            wait_for_reads();
        else if (pick < 8 && full_rows.size() < 48)
            fill_row(ROW_W'($urandom));
        else if (pick < 13)
            send_paced(OP_CLEAR, HASH_W'($urandom), ROW_W'($urandom), VAL_W'($urandom));
        else if (pick < 28)
            send_paced(OP_LOAD, HASH_W'($urandom), ROW_W'($urandom), VAL_W'($urandom));
        else if (pick < 67)
            send_paced(OP_ADD, HASH_W'($urandom), pick_add_row(), VAL_W'($urandom));
        else
            send_paced(OP_READ, HASH_W'($urandom), ROW_W'($urandom), VAL_W'($urandom));
    endtask

    task automatic test_random_phases();
        logic [CNT_W-1:0] settings [8] = '{4'd8, 4'd1, 4'd5, 4'd15, 4'd0, 4'd3, 4'd12, 4'd8};
        int unsigned start;
        foreach (settings[k]) begin
            set_active_hashes(settings[k]);
            burst_left = $urandom_range(1, 16);
            start = items_sent;
            while (items_sent - start < PHASE_ITEMS)
                random_item();
        end
    endtask

    // Receiver: random ready pattern in stretches, overridden by a requested hold.
    always @(negedge i_clk) begin
        if (out_hold_cycles > 0) begin
            i_out_ready <= 1'b0;
            out_hold_cycles--;
        end else begin
            if (rx_left == 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_left = $urandom_range(8, 80);
            end
            rx_left--;
            case (rx_mode)
                0:       i_out_ready <= 1'b1;
                1:       i_out_ready <= $urandom_range(0, 1);
                2:       i_out_ready <= ($urandom_range(0, 3) == 0);
                default: i_out_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_reads.size() == 0) begin
                $error("unexpected read beat: min_value %0d, is_empty %0d",
                       o_min_value, o_is_empty);
                mismatches++;
            end else begin
                read_due = pending_reads.pop_front();
                if (o_min_value !== read_due.min_value) begin
                    $error("min_value: expected %0d, got %0d", read_due.min_value, o_min_value);
                    mismatches++;
                end
                if (o_is_empty !== read_due.is_empty) begin
                    $error("is_empty: expected %0d, got %0d", read_due.is_empty, o_is_empty);
                    mismatches++;
                end
                if (read_due.is_empty)
                    reads_empty++;
                else
                    reads_filled++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_op         = OP_CLEAR;
        i_hash_index = '0;
        i_row_index  = '0;
        i_perm_value = '0;
        i_out_ready  = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_data   = ACTIVE_RESET;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_state();
        test_first_add();
        test_active_count();
        test_clear();
        test_output_stall();
        test_random_phases();

        wait_for_reads();
        repeat (8) @(posedge i_clk);
        $display("Run covered %0d items: %0d adds, %0d loads, %0d clears, %0d config writes.",
                 items_sent, adds_sent, loads_sent, clears_sent, cfg_writes);
        $display("Read beats checked: %0d empty, %0d holding a minimum; one long output hold.",
                 reads_empty, reads_filled);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+src
src/mhs_pkg.sv
src/mhs_perm_lane.sv
src/mhs_slot_bank.sv
src/minhash_signature_update.sv
tb/sv/testbench.sv
